// ===== hdl/adfs_pkg.sv =====
package adfs_pkg;

    localparam int NV = 16;
    localparam int VW = 4;
    localparam int DW = 5;
    localparam int ETW = 9;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_QUERY = 3'd2;
    localparam logic [2:0] OP_ORDER = 3'd3;
    localparam logic [2:0] OP_TREE  = 3'd4;
    localparam logic [2:0] OP_CONN  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DISC  = 2'd2;

    localparam logic REG_DIRECTED = 1'b0;
    localparam logic REG_VCOUNT   = 1'b1;

    typedef logic [NV-1:0] row_t;
    typedef logic [VW-1:0] vtx_t;

    typedef struct packed {
        logic en;
        vtx_t addr;
        row_t data;
    } adj_wr_t;

    typedef struct packed {
        logic en;
        vtx_t addr;
        vtx_t data;
    } stk_wr_t;

    // index of the lowest set bit
    function automatic vtx_t lowest_bit(input row_t r);
        vtx_t idx;
        idx = '0;
        for (int i = NV - 1; i >= 0; i--)
        begin
            if (r[i])
            begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/adfs_adj_mem.sv =====
module adfs_adj_mem
    import adfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clear_all,
    input  adj_wr_t wr,
    input  logic    re,
    input  vtx_t    raddr,
    output row_t    rdata
);

    row_t            mem [NV];
    logic [NV-1:0]   row_vld_reg;
    row_t            row_q_reg;
    logic            vld_q_reg;

    // row valid bits give the all-zero matrix after reset and clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (clear_all)
        begin
            row_vld_reg <= '0;
        end
        else if (wr.en)
        begin
            row_vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (re)
        begin
            row_q_reg <= mem[raddr];
            vld_q_reg <= row_vld_reg[raddr];
        end
    end

    assign rdata = vld_q_reg ? row_q_reg : '0;

endmodule

// ===== hdl/adfs_stack_mem.sv =====
module adfs_stack_mem
    import adfs_pkg::*;
(
    input  logic    clk,
    input  stk_wr_t wr,
    input  logic    re,
    input  vtx_t    raddr,
    output vtx_t    rdata
);

    vtx_t mem [NV];
    vtx_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/adjacency_matrix_dfs_engine.sv =====
// Depth-first search engine over a 16 x 16 adjacency bit matrix. One input
// beat carries an operation (add edge, clear, query edge, depth-first order,
// spanning tree, connectivity) and produces one or more result beats, the
// final one flagged by m_tlast. The matrix sits in a synchronous row memory
// and the walk stack in a second small memory; the controller reads a row,
// picks the lowest unvisited neighbor and pushes it, or pops the stack. A new
// beat is taken only once the previous operation has finished. A directed
// connectivity test runs one walk from each vertex in turn, stopping at the
// first that misses a vertex. Result beats wait in an output register, so a
// stalled master side holds the walk only when that register is full.
module adjacency_matrix_dfs_engine
    import adfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // first_vertex[3:0], second_vertex[7:4]
    input  logic [2:0]  s_tuser,    // operation
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // vertex_id[3:0], parent_vertex[7:4], status[9:8],
                                    // edge_present[10], connected[11], edge_count[20:12]
    output logic        m_tuser,    // item_valid
    output logic        m_tlast
);

    // controller states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_ADD_CHK = 4'd2;
    localparam logic [3:0] S_ADD_WR2 = 4'd3;
    localparam logic [3:0] S_QRY     = 4'd4;
    localparam logic [3:0] S_START   = 4'd5;
    localparam logic [3:0] S_READ    = 4'd6;
    localparam logic [3:0] S_SCAN    = 4'd7;
    localparam logic [3:0] S_POP     = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    // walk purposes
    localparam logic [1:0] MODE_ORDER = 2'd0;
    localparam logic [1:0] MODE_CONN  = 2'd1;
    localparam logic [1:0] MODE_TREE  = 2'd2;

    logic               directed_reg;
    logic [4:0]         vcount_reg;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [2:0]         op_reg;
    vtx_t               u_reg, v_reg;
    vtx_t               src_reg, src_next;
    vtx_t               iter_reg, iter_next;
    vtx_t               top_reg, top_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [DW-1:0]      cnt_reg, cnt_next;
    row_t               visited_reg, visited_next;
    logic [ETW-1:0]     edge_total_reg, edge_total_next;

    // output register
    logic               out_valid_reg;
    vtx_t               o_vid_reg, o_par_reg;
    logic               o_ivalid_reg, o_present_reg, o_conn_reg, o_last_reg;
    logic [1:0]         o_status_reg;
    logic [ETW-1:0]     o_ecount_reg;

    // emit request
    logic               emit;
    vtx_t               e_vid, e_par;
    logic               e_ivalid, e_present, e_conn, e_last;
    logic [1:0]         e_status;

    logic               out_free;
    logic [4:0]         n_eff;
    row_t               mask;
    logic               u_oor, v_oor;

    adj_wr_t            adj_wr;
    logic               adj_re, adj_clear;
    vtx_t               adj_raddr;
    row_t               adj_rdata;
    stk_wr_t            stk_wr;
    logic               stk_re;
    vtx_t               stk_raddr;
    vtx_t               stk_rdata;

    row_t               avail, unvisited;
    vtx_t               w;
    logic               walk_ok;

    adfs_adj_mem u_adj (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (adj_clear),
        .wr        (adj_wr),
        .re        (adj_re),
        .raddr     (adj_raddr),
        .rdata     (adj_rdata)
    );

    adfs_stack_mem u_stk (
        .clk   (clk),
        .wr    (stk_wr),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // effective vertex count, 1 to 16
    always_comb
    begin
        if (vcount_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (vcount_reg > 5'(NV))
        begin
            n_eff = 5'(NV);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    assign mask      = ~(row_t'('1) << n_eff);
    assign u_oor     = {1'b0, u_reg} >= n_eff;
    assign v_oor     = {1'b0, v_reg} >= n_eff;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign avail     = adj_rdata & mask & ~visited_reg;
    assign w         = lowest_bit(avail);
    assign unvisited = mask & ~visited_reg;
    assign walk_ok   = (visited_reg & mask) == mask;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg <= 1'b0;
            vcount_reg   <= 5'(NV);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIRECTED: directed_reg <= cfg_wdata[0];
                REG_VCOUNT:   vcount_reg   <= cfg_wdata;
                default:      vcount_reg   <= vcount_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        src_next        = src_reg;
        iter_next       = iter_reg;
        top_next        = top_reg;
        depth_next      = depth_reg;
        cnt_next        = cnt_reg;
        visited_next    = visited_reg;
        edge_total_next = edge_total_reg;

        emit      = 1'b0;
        e_vid     = '0;
        e_par     = '0;
        e_ivalid  = 1'b0;
        e_status  = ST_OK;
        e_present = 1'b0;
        e_conn    = 1'b0;
        e_last    = 1'b1;

        adj_clear = 1'b0;
        adj_wr    = '0;
        adj_re    = 1'b0;
        adj_raddr = u_reg;
        stk_wr    = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                if (out_free)
                begin
                    case (op_reg)
                        OP_ADD, OP_QUERY:
                        begin
                            if (u_oor || v_oor)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_RANGE;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                adj_re     = 1'b1;
                                state_next = (op_reg == OP_ADD) ? S_ADD_CHK : S_QRY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            adj_clear       = 1'b1;
                            edge_total_next = '0;
                            emit            = 1'b1;
                            state_next      = S_IDLE;
                        end
                        OP_ORDER, OP_TREE, OP_CONN:
                        begin
                            if (v_oor && op_reg != OP_CONN)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_RANGE;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                visited_next = '0;
                                cnt_next     = '0;
                                iter_next    = '0;
                                mode_next    = (op_reg == OP_ORDER) ? MODE_ORDER : MODE_CONN;
                                src_next     = (op_reg == OP_ORDER) ? v_reg : '0;
                                state_next   = S_START;
                            end
                        end
                        default:
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_CHK:
            begin
                if (out_free)
                begin
                    if (adj_rdata[v_reg])
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        adj_wr.en   = 1'b1;
                        adj_wr.addr = u_reg;
                        adj_wr.data = adj_rdata | (row_t'(1) << v_reg);
                        if (edge_total_reg != '1)
                        begin
                            edge_total_next = edge_total_reg + 1'b1;
                        end
                        if (directed_reg || u_reg == v_reg)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            adj_re     = 1'b1;
                            adj_raddr  = v_reg;
                            state_next = S_ADD_WR2;
                        end
                    end
                end
            end

            S_ADD_WR2:
            begin
                if (out_free)
                begin
                    adj_wr.en   = 1'b1;
                    adj_wr.addr = v_reg;
                    adj_wr.data = adj_rdata | (row_t'(1) << u_reg);
                    emit        = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_QRY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_present  = adj_rdata[v_reg];
                    state_next = S_IDLE;
                end
            end

            S_START:
            begin
                if (out_free || mode_reg != MODE_ORDER)
                begin
                    visited_next   = visited_reg | (row_t'(1) << src_reg);
                    stk_wr.en      = 1'b1;
                    stk_wr.addr    = '0;
                    stk_wr.data    = src_reg;
                    depth_next     = DW'(1);
                    top_next       = src_reg;
                    if (mode_reg == MODE_ORDER)
                    begin
                        emit     = 1'b1;
                        e_vid    = src_reg;
                        e_ivalid = 1'b1;
                        e_last   = (cnt_reg + 1'b1) == n_eff;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                adj_re     = 1'b1;
                adj_raddr  = top_reg;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (avail == '0)
                begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == DW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        stk_raddr  = VW'(depth_reg - DW'(2));
                        state_next = S_POP;
                    end
                end
                else if (out_free || mode_reg == MODE_CONN)
                begin
                    visited_next = visited_reg | (row_t'(1) << w);
                    stk_wr.en    = 1'b1;
                    stk_wr.addr  = depth_reg[VW-1:0];
                    stk_wr.data  = w;
                    depth_next   = depth_reg + 1'b1;
                    top_next     = w;
                    cnt_next     = cnt_reg + 1'b1;
                    if (mode_reg != MODE_CONN)
                    begin
                        emit     = 1'b1;
                        e_vid    = w;
                        e_ivalid = 1'b1;
                        if (mode_reg == MODE_TREE)
                        begin
                            e_par  = top_reg;
                            e_conn = 1'b1;
                            e_last = (cnt_reg + DW'(2)) == n_eff;
                        end
                        else
                        begin
                            e_last = (cnt_reg + 1'b1) == n_eff;
                        end
                    end
                    state_next = S_READ;
                end
            end

            S_POP:
            begin
                // new top arrives from the stack; fetch its row at once
                top_next   = stk_rdata;
                adj_re     = 1'b1;
                adj_raddr  = stk_rdata;
                state_next = S_SCAN;
            end

            S_DONE:
            begin
                case (mode_reg)
                    MODE_ORDER:
                    begin
                        if (unvisited == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            src_next   = lowest_bit(unvisited);
                            state_next = S_START;
                        end
                    end
                    MODE_CONN:
                    begin
                        if (walk_ok && directed_reg && ({1'b0, iter_reg} + 1'b1) < n_eff)
                        begin
                            iter_next    = iter_reg + 1'b1;
                            src_next     = iter_reg + 1'b1;
                            visited_next = '0;
                            state_next   = S_START;
                        end
                        else if (out_free)
                        begin
                            if (op_reg == OP_CONN)
                            begin
                                emit       = 1'b1;
                                e_conn     = walk_ok;
                                state_next = S_IDLE;
                            end
                            else if (!walk_ok)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_DISC;
                                state_next = S_IDLE;
                            end
                            else if (n_eff == 5'd1)
                            begin
                                emit       = 1'b1;
                                e_conn     = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                mode_next    = MODE_TREE;
                                visited_next = '0;
                                cnt_next     = '0;
                                src_next     = v_reg;
                                state_next   = S_START;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_ORDER;
            src_reg        <= '0;
            iter_reg       <= '0;
            top_reg        <= '0;
            depth_reg      <= '0;
            cnt_reg        <= '0;
            visited_reg    <= '0;
            edge_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            src_reg        <= src_next;
            iter_reg       <= iter_next;
            top_reg        <= top_next;
            depth_reg      <= depth_next;
            cnt_reg        <= cnt_next;
            visited_reg    <= visited_next;
            edge_total_reg <= edge_total_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // captured beat and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tuser;
            u_reg  <= s_tdata[3:0];
            v_reg  <= s_tdata[7:4];
        end
        if (emit)
        begin
            o_vid_reg     <= e_vid;
            o_par_reg     <= e_par;
            o_ivalid_reg  <= e_ivalid;
            o_status_reg  <= e_status;
            o_present_reg <= e_present;
            o_conn_reg    <= e_conn;
            o_ecount_reg  <= edge_total_next;
            o_last_reg    <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, o_ecount_reg, o_conn_reg, o_present_reg, o_status_reg,
                       o_par_reg, o_vid_reg};
    assign m_tuser  = o_ivalid_reg;
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    // a result is never loaded over one that the master side has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result register overwritten");

    // the walk stack never grows past its NV entries
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(NV))
        else $error("walk stack overflow");

    // a scan only ever sees marks of vertices in use
    a_visited_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((visited_reg & ~mask) == '0))
        else $error("visit mark outside vertex range");

    // the edge counter only drops on a clear
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_total_reg < $past(edge_total_reg)) |-> $past(adj_clear))
        else $error("edge counter dropped without clear");
`endif

endmodule
